[rtl/core/humidity_sensor_measure_sequencer_macros.svh]
// Assertion macros used by the checker of the sequencer.
`ifndef HUMIDITY_SENSOR_MEASURE_SEQUENCER_MACROS_SVH
`define HUMIDITY_SENSOR_MEASURE_SEQUENCER_MACROS_SVH

// Check a property outside reset.
`define HSMS_CHECK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define HSMS_CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/hsms_pkg.sv]
`default_nettype none
package hsms_pkg;

  localparam logic [2:0] OP_TEMP  = 3'd0;
  localparam logic [2:0] OP_HUM   = 3'd1;
  localparam logic [2:0] OP_RDREG = 3'd2;
  localparam logic [2:0] OP_WRREG = 3'd3;
  localparam logic [2:0] OP_RESET = 3'd4;
  localparam logic [2:0] OP_RESP  = 3'd5;
  localparam logic [2:0] OP_TICK  = 3'd6;

  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_RDACK  = 3'd2;
  localparam logic [2:0] CMD_RDNACK = 3'd3;
  localparam logic [2:0] CMD_STOP   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NACK    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_CRC     = 2'd3;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_POLL_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_POLL_INTERVAL  = 2'd2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_value;
    logic       response_ack;
    logic [7:0] response_byte;
  } hsms_item_t;

  typedef struct packed {
    logic              out_kind;
    logic [2:0]        bus_command;
    logic [7:0]        bus_byte;
    logic [1:0]        done_status;
    logic signed [14:0] measured_value;
    logic [7:0]        register_value;
  } hsms_result_t;

endpackage
`default_nettype wire

[rtl/core/hsms_in_stage.sv]
`default_nettype none
module hsms_in_stage (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [2:0]                      in_tuser,  // opcode
  // write_value[7:0], response_ack[8], response_byte[16:9], zero fill
  input  wire logic [hsms_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                            down_ready,
  output logic                                 s1_valid,
  output hsms_pkg::hsms_item_t                 s1_item
);
  import hsms_pkg::*;

  logic       valid_r, valid_nxt;
  hsms_item_t item_r;
  logic       take;

  assign in_tready = !valid_r || down_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.opcode        <= in_tuser;
      item_r.write_value   <= in_tdata[7:0];
      item_r.response_ack  <= in_tdata[8];
      item_r.response_byte <= in_tdata[16:9];
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule
`default_nettype wire

[rtl/core/hsms_seq.sv]
`default_nettype none
module hsms_seq (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [hsms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hsms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            step,
  input  wire hsms_pkg::hsms_item_t            item,
  output logic                                 res_valid,
  output hsms_pkg::hsms_result_t               res
);
  import hsms_pkg::*;

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_START1   = 5'd1;
  localparam logic [4:0] PH_ADDRW    = 5'd2;
  localparam logic [4:0] PH_CMD      = 5'd3;
  localparam logic [4:0] PH_VAL      = 5'd4;
  localparam logic [4:0] PH_START2   = 5'd5;
  localparam logic [4:0] PH_ADDRR    = 5'd6;
  localparam logic [4:0] PH_RDREG    = 5'd7;
  localparam logic [4:0] PH_STOP_CMD = 5'd8;
  localparam logic [4:0] PH_STOP_END = 5'd9;
  localparam logic [4:0] PH_WAIT     = 5'd10;
  localparam logic [4:0] PH_PSTART   = 5'd11;
  localparam logic [4:0] PH_PADDR    = 5'd12;
  localparam logic [4:0] PH_RD0      = 5'd13;
  localparam logic [4:0] PH_RD1      = 5'd14;
  localparam logic [4:0] PH_RD2      = 5'd15;
  localparam logic [4:0] PH_PSTOP    = 5'd16;
  localparam logic [4:0] PH_DSTOP    = 5'd17;

  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [7:0] SCMD_TEMP  = 8'hF3;
  localparam logic [7:0] SCMD_HUM   = 8'hF5;
  localparam logic [7:0] SCMD_RDREG = 8'hE7;
  localparam logic [7:0] SCMD_WRREG = 8'hE6;
  localparam logic [7:0] SCMD_RESET = 8'hFE;
  localparam logic [7:0] RAW_MASK   = 8'hFC;

  localparam logic [14:0]        TEMP_COEF = 15'd17572;
  localparam logic [14:0]        HUM_COEF  = 15'd12500;
  localparam logic signed [15:0] TEMP_OFS  = 16'sd4685;
  localparam logic signed [15:0] HUM_OFS   = 16'sd600;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic [6:0]  dev_addr_r;
  logic [7:0]  poll_limit_r;
  logic [15:0] poll_ivl_r;

  logic [4:0]  phase_r, phase_nxt;
  logic [2:0]  act_op_r, act_op_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  attempt_r, attempt_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [7:0]  rb_r [3];
  logic [7:0]  rb_nxt [3];
  logic [7:0]  crc_r, crc_nxt;

  logic [7:0]         waddr;
  logic [15:0]        tick_inc;
  logic [15:0]        raw;
  logic [14:0]        coef;
  logic signed [15:0] ofs;
  logic [30:0]        prod;
  logic signed [15:0] conv;
  logic [7:0]         scmd;

  assign waddr    = {dev_addr_r, 1'b0};
  assign tick_inc = (tick_r == 16'hFFFF) ? tick_r : tick_r + 16'd1;
  assign raw      = {rb_r[0], rb_r[1] & RAW_MASK};
  assign coef     = (act_op_r == OP_TEMP) ? TEMP_COEF : HUM_COEF;
  assign ofs      = (act_op_r == OP_TEMP) ? TEMP_OFS : HUM_OFS;
  assign prod     = coef * raw;
  assign conv     = $signed({1'b0, prod[30:16]}) - ofs;

  always_comb begin
    case (act_op_r)
      OP_TEMP:  scmd = SCMD_TEMP;
      OP_HUM:   scmd = SCMD_HUM;
      OP_RDREG: scmd = SCMD_RDREG;
      OP_WRREG: scmd = SCMD_WRREG;
      default:  scmd = SCMD_RESET;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= 7'd64;
      poll_limit_r <= 8'd85;
      poll_ivl_r   <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: dev_addr_r   <= cfg_wdata[6:0];
        CFG_POLL_LIMIT:     poll_limit_r <= cfg_wdata[7:0];
        CFG_POLL_INTERVAL:  poll_ivl_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    act_op_nxt  = act_op_r;
    tick_nxt    = tick_r;
    attempt_nxt = attempt_r;
    pend_nxt    = pend_r;
    rb_nxt      = rb_r;
    crc_nxt     = crc_r;
    res_valid   = 1'b0;
    res         = '0;
    if (step) begin
      if (item.opcode <= OP_RESET) begin
        if (phase_r == PH_IDLE) begin
          act_op_nxt = item.opcode;
          pend_nxt   = ST_OK;
          if (item.opcode == OP_WRREG) begin
            rb_nxt[0] = item.write_value;
          end
          phase_nxt       = PH_START1;
          res_valid       = 1'b1;
          res.bus_command = CMD_START;
        end
      end else if (item.opcode == OP_TICK) begin
        if (phase_r == PH_WAIT) begin
          tick_nxt = tick_inc;
          if (tick_inc >= poll_ivl_r) begin
            tick_nxt        = '0;
            attempt_nxt     = (attempt_r == 8'hFF) ? attempt_r : attempt_r + 8'd1;
            phase_nxt       = PH_PSTART;
            res_valid       = 1'b1;
            res.bus_command = CMD_START;
          end
        end
      end else if (item.opcode == OP_RESP) begin
        unique case (phase_r) inside
          PH_START1: begin
            phase_nxt       = PH_ADDRW;
            res_valid       = 1'b1;
            res.bus_command = CMD_WRITE;
            res.bus_byte    = waddr;
          end
          PH_ADDRW, PH_CMD, PH_VAL, PH_ADDRR: begin
            res_valid = 1'b1;
            if (!item.response_ack) begin
              pend_nxt        = ST_NACK;
              phase_nxt       = PH_STOP_END;
              res.bus_command = CMD_STOP;
            end else if (phase_r == PH_ADDRW) begin
              phase_nxt       = PH_CMD;
              res.bus_command = CMD_WRITE;
              res.bus_byte    = scmd;
            end else if (phase_r == PH_ADDRR) begin
              phase_nxt       = PH_RDREG;
              res.bus_command = CMD_RDNACK;
            end else if (phase_r == PH_VAL) begin
              phase_nxt       = PH_STOP_END;
              res.bus_command = CMD_STOP;
            end else if (act_op_r == OP_RDREG) begin
              phase_nxt       = PH_START2;
              res.bus_command = CMD_START;
            end else if (act_op_r == OP_WRREG) begin
              phase_nxt       = PH_VAL;
              res.bus_command = CMD_WRITE;
              res.bus_byte    = rb_r[0];
            end else begin
              phase_nxt       = (act_op_r <= OP_HUM) ? PH_STOP_CMD : PH_STOP_END;
              res.bus_command = CMD_STOP;
            end
          end
          PH_START2, PH_PSTART: begin
            phase_nxt       = (phase_r == PH_START2) ? PH_ADDRR : PH_PADDR;
            res_valid       = 1'b1;
            res.bus_command = CMD_WRITE;
            res.bus_byte    = waddr | 8'd1;
          end
          PH_RDREG: begin
            rb_nxt[0]       = item.response_byte;
            phase_nxt       = PH_STOP_END;
            res_valid       = 1'b1;
            res.bus_command = CMD_STOP;
          end
          PH_STOP_END: begin
            phase_nxt       = PH_IDLE;
            res_valid       = 1'b1;
            res.out_kind    = KIND_DONE;
            res.done_status = pend_r;
            if (pend_r == ST_OK && act_op_r == OP_RDREG) begin
              res.register_value = rb_r[0];
            end
          end
          PH_STOP_CMD: begin
            tick_nxt    = '0;
            attempt_nxt = '0;
            if (poll_limit_r == 8'd0) begin
              phase_nxt       = PH_IDLE;
              res_valid       = 1'b1;
              res.out_kind    = KIND_DONE;
              res.done_status = ST_TIMEOUT;
            end else begin
              phase_nxt = PH_WAIT;
            end
          end
          PH_PADDR: begin
            res_valid = 1'b1;
            if (!item.response_ack) begin
              phase_nxt       = PH_PSTOP;
              res.bus_command = CMD_STOP;
            end else begin
              phase_nxt       = PH_RD0;
              res.bus_command = CMD_RDACK;
            end
          end
          PH_RD0: begin
            rb_nxt[0]       = item.response_byte;
            crc_nxt         = crc_byte(8'd0, item.response_byte);
            phase_nxt       = PH_RD1;
            res_valid       = 1'b1;
            res.bus_command = CMD_RDACK;
          end
          PH_RD1: begin
            rb_nxt[1]       = item.response_byte;
            crc_nxt         = crc_byte(crc_r, item.response_byte);
            phase_nxt       = PH_RD2;
            res_valid       = 1'b1;
            res.bus_command = CMD_RDNACK;
          end
          PH_RD2: begin
            rb_nxt[2]       = item.response_byte;
            phase_nxt       = PH_DSTOP;
            res_valid       = 1'b1;
            res.bus_command = CMD_STOP;
          end
          PH_PSTOP: begin
            if (attempt_r >= poll_limit_r) begin
              phase_nxt       = PH_IDLE;
              res_valid       = 1'b1;
              res.out_kind    = KIND_DONE;
              res.done_status = ST_TIMEOUT;
            end else begin
              tick_nxt  = '0;
              phase_nxt = PH_WAIT;
            end
          end
          PH_DSTOP: begin
            phase_nxt    = PH_IDLE;
            res_valid    = 1'b1;
            res.out_kind = KIND_DONE;
            if (crc_r != rb_r[2]) begin
              res.done_status = ST_CRC;
            end else begin
              res.measured_value = conv[14:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      act_op_r  <= OP_TEMP;
      tick_r    <= '0;
      attempt_r <= '0;
      pend_r    <= ST_OK;
    end else begin
      phase_r   <= phase_nxt;
      act_op_r  <= act_op_nxt;
      tick_r    <= tick_nxt;
      attempt_r <= attempt_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rb_r  <= rb_nxt;
    crc_r <= crc_nxt;
  end

endmodule
`default_nettype wire

[rtl/core/hsms_out_stage.sv]
`default_nettype none
module hsms_out_stage (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  output logic                                  down_ready,
  input  wire logic                             load,
  input  wire logic                             res_valid,
  input  wire hsms_pkg::hsms_result_t           res,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic                                  out_tuser,  // out_kind
  // bus_command[2:0], bus_byte[10:3], done_status[12:11],
  // measured_value[27:13], register_value[35:28], zero fill
  output logic [hsms_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import hsms_pkg::*;

  logic         valid_r, valid_nxt;
  hsms_result_t res_r;

  assign down_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (down_ready) begin
      valid_nxt = load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid && down_ready) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.out_kind;
  assign out_tdata  = {4'b0000, res_r.register_value, res_r.measured_value,
                       res_r.done_status, res_r.bus_byte, res_r.bus_command};

endmodule
`default_nettype wire

[rtl/core/humidity_sensor_measure_sequencer.sv]
`default_nettype none
// Humidity sensor measurement sequencer. Takes one input word per clock while
// the output does not stall. Each accepted word is captured in an input
// register, makes a single pass through the phase decode, CRC byte step and
// constant-multiply conversion, and its result word, if it causes one, lands
// in a result register. A stalled output holds the result register and the
// input register, so input stalls with it.
// Requests (temperature, humidity, read or write user register, soft reset)
// start a bus transaction; every bus command issued (out_tuser 0) must be
// answered by one bus-response word, and ticks pace the ready polling of a
// measurement. A completion (out_tuser 1) ends each transaction. Requests that
// arrive while a transaction runs are dropped. Write configuration only
// while no transaction is running.
module humidity_sensor_measure_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [2:0]                       in_tuser,  // opcode
  // write_value[7:0], response_ack[8], response_byte[16:9], zero fill
  input  wire logic [hsms_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic                                  out_tuser,  // out_kind
  // bus_command[2:0], bus_byte[10:3], done_status[12:11],
  // measured_value[27:13], register_value[35:28], zero fill
  output logic [hsms_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [hsms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hsms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import hsms_pkg::*;

  logic         down_ready;
  logic         s1_valid;
  hsms_item_t   s1_item;
  logic         step;
  logic         res_valid;
  hsms_result_t res;

  assign step = s1_valid && down_ready;

  hsms_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .down_ready (down_ready),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item)
  );

  hsms_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  hsms_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .down_ready (down_ready),
    .load       (step),
    .res_valid  (res_valid),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

[rtl/core/hsms_checker.sv]
`default_nettype none
`include "humidity_sensor_measure_sequencer_macros.svh"
module hsms_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic                            out_tuser,
  input wire logic [hsms_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import hsms_pkg::*;

  `HSMS_CHECK(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled output word changed")
  `HSMS_CHECK(a_done_clean, clk, rst_n, out_tvalid && out_tuser == KIND_DONE |-> out_tdata[10:0] == 11'd0, "completion carries a bus command")
  `HSMS_CHECK(a_cmd_clean, clk, rst_n, out_tvalid && out_tuser == KIND_CMD |-> out_tdata[35:11] == 25'd0 && out_tdata[2:0] <= CMD_STOP, "bad bus command word")
  `HSMS_CHECK_ALWAYS(a_reset, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind humidity_sensor_measure_sequencer hsms_checker u_hsms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
`default_nettype wire
